/* rtl/core/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and digit glyph mapping for the
// integer to radix text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [5:0] DIGIT_TEN   = 6'd10;
	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd10;

	// register word index, taken from paddr[2]
	localparam logic REG_RADIX = 1'b0;

	typedef struct packed {
		logic neg;
		logic zero;
	} itoa_flags_t;

	function automatic logic [7:0] glyph(input logic [5:0] d);
		logic [7:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + {2'b00, d};
		end else begin
			c = CHAR_A + {2'b00, d - DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

/* rtl/core/itoa_front.sv */
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input requests, splits each value into sign, zero mark and
// magnitude, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module itoa_front
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   q_valid,
	output itoa_flags_t            q_flags,
	output logic [VALUE_WIDTH-1:0] q_mag,
	input  logic                   q_pop
);

	itoa_flags_t            flags_q [2];
	logic [VALUE_WIDTH-1:0] mag_q   [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             cnt_q;

	itoa_flags_t            cls_flags;
	logic [VALUE_WIDTH-1:0] cls_mag;
	logic                   push;

	always_comb begin
		cls_flags.neg  = value[VALUE_WIDTH-1];
		cls_flags.zero = (value == '0);
		// most negative value wraps to itself, which is its exact magnitude
		cls_mag = cls_flags.neg ? VALUE_WIDTH'(-value) : value;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_flags  = flags_q[rd_ptr_q];
	assign q_mag    = mag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			flags_q[wr_ptr_q] <= cls_flags;
			mag_q[wr_ptr_q]   <= cls_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/itoa_div.sv */
// ----------------------------------------------------------------------------
// itoa_div
// Iterative divider of the magnitude by the base: eight restoring steps
// per cycle, MSB first. The quotient replaces the dividend in the shift
// register; the remainder stays below the base and fits six bits.
// ----------------------------------------------------------------------------
module itoa_div
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [5:0]             divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quot,
	output logic [5:0]             rem
);

	localparam int STEP  = 8;
	localparam int CYC   = (VALUE_WIDTH + STEP - 1) / STEP;
	localparam int PAD_W = CYC * STEP;
	localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

	logic [PAD_W-1:0] sh_q;
	logic [5:0]       rem_q;
	logic [5:0]       d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [5:0]      r_next;
	logic [STEP-1:0] qbits;

	always_comb begin
		logic [6:0] t;
		logic [5:0] r;
		r = rem_q;
		qbits = '0;
		for (int j = 0; j < STEP; j++) begin
			t = {r, sh_q[PAD_W-1-j]};
			if (t >= {1'b0, d_q}) begin
				r = 6'(t - {1'b0, d_q});
				qbits[STEP-1-j] = 1'b1;
			end else begin
				r = t[5:0];
			end
		end
		r_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CYC - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PAD_W'(dividend);
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			// shift the new quotient bits in at the bottom
			sh_q  <= PAD_W'({sh_q, qbits});
			rem_q <= r_next;
		end
	end

	assign done = done_q;
	assign quot = sh_q[VALUE_WIDTH-1:0];
	assign rem  = rem_q;

endmodule

/* rtl/core/itoa_back.sv */
// ----------------------------------------------------------------------------
// itoa_back
// Takes classified values from the queue, drives the divider, keeps the
// digits in a small store and sends the text out MSB first through an
// output register.
// ----------------------------------------------------------------------------
module itoa_back
	import itoa_pkg::*;
#(
	parameter int DIGIT_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [5:0]             base,
	input  logic                   q_valid,
	input  itoa_flags_t            q_flags,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	output logic                   q_pop,
	output logic                   div_start,
	output logic [VALUE_WIDTH-1:0] div_dividend,
	output logic [5:0]             div_divisor,
	input  logic                   div_done,
	input  logic [VALUE_WIDTH-1:0] div_quot,
	input  logic [5:0]             div_rem,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             char_code,
	output logic                   last_char
);

	localparam int IDX_W = $clog2(DIGIT_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ZERO,
		S_SIGN,
		S_READ,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             neg_q;
	logic             ovalid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic [5:0] mem [DIGIT_DEPTH];
	logic [5:0] rd_q;

	logic out_free;
	logic emit_now;
	logic div_stop;
	logic wr_en;

	assign out_free = !ovalid_q || !out_stall;
	assign emit_now = (state_q == S_ZERO) || (state_q == S_SIGN) || (state_q == S_EMIT);
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign div_stop = (div_quot == '0) || (cnt_q == LAST_IDX);
	assign wr_en    = (state_q == S_DIV) && div_done;

	assign div_start    = (q_pop && !q_flags.zero) || (wr_en && !div_stop);
	assign div_dividend = (state_q == S_IDLE) ? q_mag : div_quot;
	assign div_divisor  = base;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q] <= div_rem;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			neg_q    <= 1'b0;
			ovalid_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			// load a new character or drop the one just taken
			if (out_free) begin
				ovalid_q <= emit_now;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						neg_q   <= q_flags.neg;
						cnt_q   <= '0;
						state_q <= q_flags.zero ? S_ZERO : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_stop) begin
							idx_q   <= cnt_q;
							state_q <= neg_q ? S_SIGN : S_READ;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				S_ZERO: begin
					if (out_free) begin
						char_q   <= CHAR_ZERO;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						char_q   <= CHAR_MINUS;
						last_q   <= 1'b0;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					// store read lands in rd_q at this edge
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						char_q   <= glyph(rd_q);
						last_q   <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

/* rtl/core/integer_to_radix_ascii_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit
// Signed integer to ASCII text in a programmable base, one character per
// output request, most significant digit first.
// ----------------------------------------------------------------------------
// Each input value becomes its text in base radix (register 0, reset 10,
// values below 2 act as 2 and above 36 as 36): an optional '-', then the
// digits of the magnitude, with last_char set on the final character; zero
// gives a single '0'. The digits come from repeated division by the base in
// the shared divider, which retires eight quotient bits per cycle; the digit
// store is read one entry per character. A two-entry queue takes new values
// while the current one is still being converted.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit
	import itoa_pkg::*;
#(
	parameter int DIGIT_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    char_code,
	output logic                          last_char
);

	logic [5:0] radix_q;
	logic [5:0] base;

	logic                   q_valid;
	itoa_flags_t            q_flags;
	logic [VALUE_WIDTH-1:0] q_mag;
	logic                   q_pop;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [5:0]             div_divisor;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [5:0]             div_rem;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX) ? {26'b0, radix_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
			radix_q <= pwdata[5:0];
		end
	end

	// saturate the base into the supported range
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	itoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value   (value),
		.q_valid (q_valid),
		.q_flags (q_flags),
		.q_mag   (q_mag),
		.q_pop   (q_pop)
	);

	itoa_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	itoa_back #(
		.DIGIT_DEPTH(DIGIT_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base        (base),
		.q_valid     (q_valid),
		.q_flags     (q_flags),
		.q_mag       (q_mag),
		.q_pop       (q_pop),
		.div_start   (div_start),
		.div_dividend(div_dividend),
		.div_divisor (div_divisor),
		.div_done    (div_done),
		.div_quot    (div_quot),
		.div_rem     (div_rem),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.char_code   (char_code),
		.last_char   (last_char)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_pop_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end popped two requests in a row");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_valid)
		else $error("queue stalls input while empty");

	a_no_start_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_done)
		else $error("divider reported done right after a start");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Converts signed integers through integer_to_radix_ascii_unit and checks
// every character against a predictor that divides the magnitude by the
// base. The base register is exercised over the full 6-bit range, including
// the values that saturate at two and at thirty-six. Both request channels
// idle and stall at random, and one long output hold-off fills the unit up.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import itoa_pkg::*;

	localparam int DIGIT_DEPTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam logic [2:0] ADDR_RADIX = {REG_RADIX, 2'b00};
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 250;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 58;
	localparam int PHASES = 6;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	class radix_text_board;
		logic [5:0] radix;
		text_char_t pending_chars[$];
		int errors;

		function new();
			radix = RADIX_RESET;
			errors = 0;
		endfunction

		function void set_radix(logic [31:0] word);
			radix = word[5:0];
		endfunction

		function logic [7:0] digit_glyph(logic [5:0] d);
			string glyphs;
			glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
			return glyphs[d];
		endfunction

		function void take_value(logic [VALUE_WIDTH-1:0] v);
			logic [31:0] base;
			logic [VALUE_WIDTH-1:0] mag;
			logic [5:0] digits[$];
			base = (radix < RADIX_MIN) ? 32'(RADIX_MIN) :
				(radix > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(radix);
			mag = v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
			if (mag == 0) begin
				pending_chars.push_back(text_char_t'{code: CHAR_ZERO, last: 1'b1});
				return;
			end
			if (v[VALUE_WIDTH-1])
				pending_chars.push_back(text_char_t'{code: CHAR_MINUS, last: 1'b0});
			// digits fall out least significant first; prepend to get reading order
			while (mag != 0 && digits.size() < DIGIT_DEPTH) begin
				digits.push_front(6'(mag % base));
				mag = mag / base;
			end
			foreach (digits[i])
				pending_chars.push_back(text_char_t'{code: digit_glyph(digits[i]),
					last: (i == digits.size() - 1)});
		endfunction

		function void match_char(logic [7:0] code, logic last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, got %h last %b",
					$time, code, last);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (want.code !== code) begin
				$display("%0t: char_code expected %h got %h", $time, want.code, code);
				errors++;
			end
			if (want.last !== last) begin
				$display("%0t: last_char expected %b got %b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [2:0]                    paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          out_valid;
	logic                          out_stall;
	logic [7:0]                    char_code;
	logic                          last_char;

	radix_text_board book;
	int send_gap_pct;
	int recv_gap_pct;
	int hold_req;
	int quiet_cycles;
	logic [5:0] phase_radix [PHASES];

	integer_to_radix_ascii_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		book.take_value(v);
	endtask

	// drop the request and wait until every character is back
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (book.pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic change_radix(input logic [5:0] r);
		settle_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_RADIX;
		pwdata <= {26'd0, r};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_radix({26'd0, r});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_WIDTH-1:0] random_value();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(5))
			0: return r;
			1: return r >> $urandom_range(31);
			2: return ~(r >> $urandom_range(31));
			3: return 32'($urandom_range(40));
			4: return 32'd0 - $urandom_range(40);
			default: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				n = hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.match_char(char_code, last_char);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		book = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		value = '0;
		quiet_cycles = 0;
		hold_req = 0;
		send_gap_pct = 30;
		recv_gap_pct = 57;
		phase_radix = '{6'd36, 6'd2, 6'($urandom_range(3, 35)), 6'($urandom_range(0, 63)),
			6'd10, 6'($urandom_range(2, 36))};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base ten straight out of reset
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd123456789);
		send_value(-32'sd987654321);
		send_value(32'd9);

		// binary: most negative value gives the longest text
		change_radix(6'd2);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'd0);
		send_value(32'd5);
		send_value(32'hFFFF_FFFF);

		change_radix(6'd36);
		send_value(32'd35);
		send_value(32'd36);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(-32'sd36);

		// out-of-range bases saturate
		change_radix(6'd0);
		send_value(32'd6);
		send_value(-32'sd6);
		change_radix(6'd1);
		send_value(32'd3);
		change_radix(6'd63);
		send_value(32'd1295);
		change_radix(6'd37);
		send_value(-32'sd1296);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_gap_pct = 57;
				recv_gap_pct = 30;
			end
			if (p == 4) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			change_radix(phase_radix[p]);
			if (p == 4)
				hold_req = HOLD_CYCLES;
			repeat (PHASE_ITEMS) send_value(random_value());
		end

		in_valid <= 1'b0;
		while (book.pending_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending_chars.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
